### rtl/tea_pkg.sv
// Shared constants, types and round functions for the TEA encipher block.
`timescale 1ns / 1ps
`default_nettype none

package tea_pkg;

  // Word width of each half of a block and of each key word.
  localparam int unsigned WORD_W = 32;

  // Default number of cipher rounds.
  localparam int unsigned ROUND_COUNT_DEF = 32;

  // Width of the configuration register index.
  localparam int unsigned CFG_INDEX_W = 8;

  // Golden-ratio constant added to the running sum once per round.
  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E37_79B9;

  // Shift amounts of the half-round mixing function.
  localparam int unsigned SHIFT_LEFT  = 4;
  localparam int unsigned SHIFT_RIGHT = 5;

  typedef logic [WORD_W-1:0] word_t;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    KEY_WORD0 = 8'd0,
    KEY_WORD1 = 8'd1,
    KEY_WORD2 = 8'd2,
    KEY_WORD3 = 8'd3
  } cfg_index_t;

  // Running sum after a given number of completed rounds plus one.
  // Only evaluated at elaboration with a constant round number.
  function automatic word_t round_sum(input int unsigned round_idx);
    logic [63:0] prod;
    prod = 64'(TEA_DELTA) * 64'(round_idx + 1);
    return prod[WORD_W-1:0];
  endfunction

  // One Feistel mixing term: three sums combined by xor.
  function automatic word_t half_round(input word_t w, input word_t sum,
                                       input word_t ka, input word_t kb);
    word_t shl_term;
    word_t sum_term;
    word_t shr_term;
    shl_term = (w << SHIFT_LEFT) + ka;
    sum_term = w + sum;
    shr_term = (w >> SHIFT_RIGHT) + kb;
    return shl_term ^ sum_term ^ shr_term;
  endfunction

endpackage

`default_nettype wire

### rtl/tea_if.sv
// Channel interfaces for plaintext, ciphertext and key configuration transfers.
`timescale 1ns / 1ps
`default_nettype none

// Plaintext block channel.
interface tea_in_if;
  logic          valid;
  logic          ready;
  tea_pkg::word_t plain_left;
  tea_pkg::word_t plain_right;

  modport source (output valid, output plain_left, output plain_right, input ready);
  modport sink   (input valid, input plain_left, input plain_right, output ready);
endinterface

// Ciphertext block channel.
interface tea_out_if;
  logic          valid;
  logic          ready;
  tea_pkg::word_t cipher_left;
  tea_pkg::word_t cipher_right;

  modport source (output valid, output cipher_left, output cipher_right, input ready);
  modport sink   (input valid, input cipher_left, input cipher_right, output ready);
endinterface

// Key register write channel.
interface tea_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [tea_pkg::CFG_INDEX_W-1:0]     reg_index;
  tea_pkg::word_t                      wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

### rtl/tea_block_encipher_core.sv
// Pipelined TEA block encipher core with key registers and stream channels.
//
// Usage:
//   in_ch carries one plaintext block (plain_left, plain_right) per transfer;
//   out_ch returns the matching ciphertext block (cipher_left, cipher_right)
//   in the same order. cfg_ch writes the four 32-bit key words at indexes
//   0 to 3; writes to any other index are accepted and ignored. cfg_ch is
//   always ready. Keys should only change while no block is in flight.
//   Every half-round has a register stage of its own, and a block is shown
//   on out_ch straight from the last stage. One block can enter every
//   cycle while the receiver does not stall: the throughput is one block
//   per cycle. When the receiver stalls with a result waiting, the whole
//   pipeline holds and in_ch.ready drops; nothing is dropped or repeated.
//   Bubbles still advance while the last stage is empty.
//   Reset (rst_n low, synchronous) empties the pipeline and clears the key
//   to all zeros.
`timescale 1ns / 1ps
`default_nettype none

module tea_block_encipher_core #(
  parameter int unsigned ROUND_COUNT = tea_pkg::ROUND_COUNT_DEF
) (
  input  wire       clk,
  input  wire       rst_n,
  tea_in_if.sink    in_ch,
  tea_out_if.source out_ch,
  tea_cfg_if.sink   cfg_ch
);

  localparam int unsigned STAGE_COUNT = 2 * ROUND_COUNT;

  // Key registers.
  tea_pkg::word_t key_r [4];

  // Pipeline registers, one stage per half-round.
  logic [STAGE_COUNT-1:0] valid_r;
  tea_pkg::word_t         left_r  [STAGE_COUNT];
  tea_pkg::word_t         right_r [STAGE_COUNT];

  // Whole pipeline advances unless a finished result is stalled.
  logic adv;
  assign adv = !valid_r[STAGE_COUNT-1] || out_ch.ready;

  assign in_ch.ready  = adv;
  assign cfg_ch.ready = 1'b1;

  // Key register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r[0] <= '0;
      key_r[1] <= '0;
      key_r[2] <= '0;
      key_r[3] <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        tea_pkg::KEY_WORD0: key_r[0] <= cfg_ch.wdata;
        tea_pkg::KEY_WORD1: key_r[1] <= cfg_ch.wdata;
        tea_pkg::KEY_WORD2: key_r[2] <= cfg_ch.wdata;
        tea_pkg::KEY_WORD3: key_r[3] <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  // Half-round stages: even stages update the left word, odd stages the right.
  for (genvar k = 0; k < STAGE_COUNT; k++) begin : g_stage
    localparam tea_pkg::word_t RoundSum = tea_pkg::round_sum(k / 2);

    logic           src_valid;
    tea_pkg::word_t src_left;
    tea_pkg::word_t src_right;
    tea_pkg::word_t left_nxt;
    tea_pkg::word_t right_nxt;

    if (k == 0) begin : g_first
      assign src_valid = in_ch.valid;
      assign src_left  = in_ch.plain_left;
      assign src_right = in_ch.plain_right;
    end else begin : g_next
      assign src_valid = valid_r[k-1];
      assign src_left  = left_r[k-1];
      assign src_right = right_r[k-1];
    end

    if (k % 2 == 0) begin : g_left
      assign left_nxt  = src_left +
                         tea_pkg::half_round(src_right, RoundSum, key_r[0], key_r[1]);
      assign right_nxt = src_right;
    end else begin : g_right
      assign left_nxt  = src_left;
      assign right_nxt = src_right +
                         tea_pkg::half_round(src_left, RoundSum, key_r[2], key_r[3]);
    end

    // Valid bit travels with the data words.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (adv) begin
        valid_r[k] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        left_r[k]  <= left_nxt;
        right_r[k] <= right_nxt;
      end
    end
  end

  // Result comes straight from the last stage.
  assign out_ch.valid        = valid_r[STAGE_COUNT-1];
  assign out_ch.cipher_left  = left_r[STAGE_COUNT-1];
  assign out_ch.cipher_right = right_r[STAGE_COUNT-1];

`ifndef SYNTHESIS
  // The pipeline comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> valid_r == '0)
    else $error("pipeline not empty after reset");

  // A stall freezes every valid bit.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(valid_r))
    else $error("valid bits moved during a stall");

  // On advance, every valid bit moves exactly one stage on.
  a_valid_shift: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> valid_r[0] == $past(in_ch.valid) &&
            (STAGE_COUNT < 2 ||
             valid_r[STAGE_COUNT-1:1] == $past(valid_r[STAGE_COUNT-2:0])))
    else $error("valid bit lost or duplicated in the pipeline");

  // Writes to unknown indexes leave the key untouched.
  a_bad_index: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ch.valid && cfg_ch.reg_index > tea_pkg::CFG_INDEX_W'(3) |=>
      $stable(key_r[0]) && $stable(key_r[1]) && $stable(key_r[2]) &&
      $stable(key_r[3]))
    else $error("key changed by a write to an unknown index");
`endif

endmodule

`default_nettype wire

### dv/tea_block_encipher_core_tb.sv
// Self-checking testbench for the pipelined TEA block encipher core.
`timescale 1ns / 1ps

module tea_block_encipher_core_tb;

  localparam int unsigned CLK_HALF         = 5;
  localparam int unsigned RESET_CYCLES     = 12;
  localparam int unsigned PIPE_DEPTH       = 2 * tea_pkg::ROUND_COUNT_DEF;
  localparam int unsigned SETTLE_CYCLES    = PIPE_DEPTH + 16;
  localparam int unsigned QUIET_LIMIT      = 5000;
  localparam int unsigned RANDOM_PER_PHASE = 96;
  localparam int unsigned PHASE_COUNT      = 4;

  // Register indexes past the last key word; the block must drop these writes.
  localparam logic [tea_pkg::CFG_INDEX_W-1:0] IDX_FIRST_UNUSED = 8'd4;
  localparam logic [tea_pkg::CFG_INDEX_W-1:0] IDX_LAST         = 8'hFF;

  typedef struct packed {
    tea_pkg::word_t left;
    tea_pkg::word_t right;
  } cipher_block_t;

  // Predicts each ciphertext block and checks what the core returns.
  class cipher_scoreboard;
    cipher_block_t  pending_ciphers[$];
    tea_pkg::word_t key_words[4];
    int unsigned    mismatches;

    function new();
      foreach (key_words[i]) key_words[i] = '0;
      mismatches = 0;
    endfunction

    function void load_key(input logic [tea_pkg::CFG_INDEX_W-1:0] idx,
                           input tea_pkg::word_t value);
      case (idx)
        tea_pkg::KEY_WORD0: key_words[0] = value;
        tea_pkg::KEY_WORD1: key_words[1] = value;
        tea_pkg::KEY_WORD2: key_words[2] = value;
        tea_pkg::KEY_WORD3: key_words[3] = value;
        default: ;
      endcase
    endfunction

    // Feistel mixing term: shifted copies and the running sum, combined by xor.
    function tea_pkg::word_t mix_term(input tea_pkg::word_t w, input tea_pkg::word_t s,
                                      input tea_pkg::word_t ka, input tea_pkg::word_t kb);
      tea_pkg::word_t shl_sum;
      tea_pkg::word_t shr_sum;
      tea_pkg::word_t run_sum;
      shl_sum = (w << tea_pkg::SHIFT_LEFT) + ka;
      shr_sum = (w >> tea_pkg::SHIFT_RIGHT) + kb;
      run_sum = w + s;
      return shl_sum ^ run_sum ^ shr_sum;
    endfunction

    function cipher_block_t encipher_block(input tea_pkg::word_t plain_l,
                                           input tea_pkg::word_t plain_r);
      cipher_block_t  blk;
      tea_pkg::word_t l;
      tea_pkg::word_t r;
      tea_pkg::word_t s;
      l = plain_l;
      r = plain_r;
      s = '0;
      for (int unsigned rnd = 0; rnd < tea_pkg::ROUND_COUNT_DEF; rnd++) begin
        s = s + tea_pkg::TEA_DELTA;
        l = l + mix_term(r, s, key_words[0], key_words[1]);
        r = r + mix_term(l, s, key_words[2], key_words[3]);
      end
      blk.left  = l;
      blk.right = r;
      return blk;
    endfunction

    function void note_plain(input tea_pkg::word_t plain_l, input tea_pkg::word_t plain_r);
      pending_ciphers.push_back(encipher_block(plain_l, plain_r));
    endfunction

    function void check_cipher(input tea_pkg::word_t cipher_l,
                               input tea_pkg::word_t cipher_r);
      cipher_block_t want;
      if (pending_ciphers.size() == 0) begin
        $error("cipher block with no plaintext pending: left=%h right=%h",
               cipher_l, cipher_r);
        mismatches++;
        return;
      end
      want = pending_ciphers.pop_front();
      if (cipher_l !== want.left) begin
        $error("cipher_left mismatch: expected %h, actual %h", want.left, cipher_l);
        mismatches++;
      end
      if (cipher_r !== want.right) begin
        $error("cipher_right mismatch: expected %h, actual %h", want.right, cipher_r);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return pending_ciphers.size();
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned quiet_cycles       = 0;

  cipher_scoreboard tracker = new();

  tea_in_if  in_bus ();
  tea_out_if out_bus ();
  tea_cfg_if cfg_bus ();

  tea_block_encipher_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // Free-running clock.
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Receiver: stalls at random and checks every ciphertext transfer.
  always @(posedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready) begin
      tracker.check_cipher(out_bus.cipher_left, out_bus.cipher_right);
    end
  end

  // Count cycles in which no channel completes a transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready === 1'b1) ||
        (out_bus.valid === 1'b1 && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: a hung core ends the run as a failure.
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("tea_block_encipher_core_tb failed");
    $finish;
  end

  // Mostly random words, with the all-zero and all-one extremes mixed in.
  function automatic tea_pkg::word_t random_word();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return tea_pkg::word_t'($urandom());
    endcase
  endfunction

  // Offer one plaintext block after a random gap and wait for its transfer.
  // Valid is left high so back-to-back blocks are sent without a gap.
  task automatic send_block(input tea_pkg::word_t plain_l, input tea_pkg::word_t plain_r);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.plain_left  <= plain_l;
    in_bus.plain_right <= plain_r;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    tracker.note_plain(plain_l, plain_r);
  endtask

  // One key register write; valid stays high for a following write.
  task automatic write_key(input logic [tea_pkg::CFG_INDEX_W-1:0] idx,
                           input tea_pkg::word_t value);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.reg_index <= idx;
    cfg_bus.wdata     <= value;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    tracker.load_key(idx, value);
  endtask

  // Load a full key, then hit unused indexes that must leave it untouched.
  task automatic load_key_set(input tea_pkg::word_t k0, input tea_pkg::word_t k1,
                              input tea_pkg::word_t k2, input tea_pkg::word_t k3);
    write_key(tea_pkg::KEY_WORD0, k0);
    write_key(tea_pkg::KEY_WORD1, k1);
    write_key(tea_pkg::KEY_WORD2, k2);
    write_key(tea_pkg::KEY_WORD3, k3);
    write_key(IDX_FIRST_UNUSED, random_word());
    write_key(IDX_LAST, random_word());
    cfg_bus.valid <= 1'b0;
  endtask

  // Stop offering blocks and wait until every ciphertext has come back.
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Extreme and alternating plaintext words, sent back to back.
  task automatic send_edge_blocks();
    send_block(32'h0000_0000, 32'h0000_0000);
    send_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_block(32'h0000_0000, 32'hFFFF_FFFF);
    send_block(32'hFFFF_FFFF, 32'h0000_0000);
    send_block(32'h8000_0000, 32'h0000_0001);
    send_block(32'h0000_0001, 32'h8000_0000);
    send_block(32'hAAAA_AAAA, 32'h5555_5555);
  endtask

  // Main sequence: directed blocks, then random phases under several keys.
  initial begin
    in_bus.valid       = 1'b0;
    in_bus.plain_left  = '0;
    in_bus.plain_right = '0;
    out_bus.ready      = 1'b0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.reg_index  = '0;
    cfg_bus.wdata      = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // The key has never been written, so the all-zero key applies.
    send_edge_blocks();
    drain();

    // Same blocks under the all-ones key.
    load_key_set('1, '1, '1, '1);
    send_edge_blocks();

    for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
      drain();
      case (phase)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 57;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 57;
        end
        default: begin
          sender_idle_pct    = 28;
          receiver_stall_pct = 28;
        end
      endcase
      load_key_set(random_word(), random_word(), random_word(), random_word());
      for (int unsigned n = 0; n < RANDOM_PER_PHASE; n++) begin
        send_block(random_word(), random_word());
        // Halfway through the second phase, let the pipeline run empty.
        if (phase == 1 && n == RANDOM_PER_PHASE / 2) begin
          drain();
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("tea_block_encipher_core_tb passed");
    end else begin
      $display("tea_block_encipher_core_tb failed");
    end
    $finish;
  end

endmodule
